### rtl/core/ple_pkg.sv
`default_nettype none
package ple_pkg;

  localparam int DEPTH      = 256;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_WRITE  = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_SWAP   = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]            cmd;
    logic [8:0]            position;
    logic [DATA_WIDTH-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [8:0]  list_length;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_RD_ORD, S_RD_ST, S_FIN, S_INS_ST, S_INS_RD, S_INS_WR,
    S_SC_RD, S_SC_WR, S_OC_RD, S_OC_WR, S_RESP
  } state_t;

  typedef enum logic [1:0] { ORA_POS, ORA_IDX_M1, ORA_SRC } ord_ra_t;
  typedef enum logic       { STA_ORD, STA_IDX1 } st_ra_t;
  typedef enum logic [1:0] { SW_NONE, SW_VAL_SLOT, SW_VAL_CNT, SW_RDATA_IDX } st_wr_t;
  typedef enum logic [1:0] { OW_NONE, OW_SHIFT_UP, OW_PUT_POS, OW_COMPACT } ord_wr_t;
  typedef enum logic [2:0] { IX_HOLD, IX_CNT, IX_SLOT, IX_ZERO, IX_INC, IX_DEC } idx_op_t;
  typedef enum logic [1:0] { CN_HOLD, CN_INC, CN_DEC, CN_CLR } cnt_op_t;

  typedef struct packed {
    logic    load;
    ord_ra_t ord_ra;
    st_ra_t  st_ra;
    logic    slot_cap;
    st_wr_t  st_wr;
    ord_wr_t ord_wr;
    idx_op_t idx_op;
    cnt_op_t cnt_op;
    logic    rv_cap;
    logic    stat_set;
    status_t stat;
    logic    out_load;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       pos_lt_cnt;
    logic       pos_le_cnt;
    logic       full;
    logic       idx_gt_pos;
    logic       idx1_lt_cnt;
    logic       out_busy;
  } sts_t;

endpackage
`default_nettype wire

### rtl/core/ple_ctrl.sv
`default_nettype none
module ple_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire ple_pkg::sts_t sts,
  output ple_pkg::ctl_t      ctl,
  output logic               busy
);

  ple_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ple_pkg::S_IDLE;
    else     state <= state_next;
  end

  assign busy = (state != ple_pkg::S_IDLE);

  always_comb begin
    state_next   = state;
    ctl          = '0;
    ctl.ord_ra   = ple_pkg::ORA_POS;
    ctl.st_ra    = ple_pkg::STA_ORD;
    ctl.st_wr    = ple_pkg::SW_NONE;
    ctl.ord_wr   = ple_pkg::OW_NONE;
    ctl.idx_op   = ple_pkg::IX_HOLD;
    ctl.cnt_op   = ple_pkg::CN_HOLD;
    ctl.stat     = ple_pkg::ST_OK;
    case (state)
      ple_pkg::S_IDLE: begin
        if (accept) begin
          ctl.load   = 1'b1;
          state_next = ple_pkg::S_CHECK;
        end
      end
      ple_pkg::S_CHECK: begin
        state_next = ple_pkg::S_RESP;
        case (sts.cmd)
          ple_pkg::CMD_READ, ple_pkg::CMD_WRITE, ple_pkg::CMD_SWAP,
          ple_pkg::CMD_REMOVE: begin
            if (sts.pos_lt_cnt) state_next = ple_pkg::S_RD_ORD;
            else begin
              ctl.stat_set = 1'b1;
              ctl.stat     = ple_pkg::ST_RANGE;
            end
          end
          ple_pkg::CMD_INSERT: begin
            if (!sts.pos_le_cnt) begin
              ctl.stat_set = 1'b1;
              ctl.stat     = ple_pkg::ST_RANGE;
            end else if (sts.full) begin
              ctl.stat_set = 1'b1;
              ctl.stat     = ple_pkg::ST_FULL;
            end else begin
              state_next = ple_pkg::S_INS_ST;
            end
          end
          ple_pkg::CMD_CLEAR: ctl.cnt_op = ple_pkg::CN_CLR;
          default: ;
        endcase
      end
      ple_pkg::S_RD_ORD: state_next = ple_pkg::S_RD_ST;
      ple_pkg::S_RD_ST: begin
        ctl.slot_cap = 1'b1;
        state_next   = ple_pkg::S_FIN;
      end
      ple_pkg::S_FIN: begin
        if (sts.cmd == ple_pkg::CMD_REMOVE) begin
          ctl.rv_cap = 1'b1;
          ctl.idx_op = ple_pkg::IX_SLOT;
          state_next = ple_pkg::S_SC_RD;
        end else begin
          ctl.rv_cap = (sts.cmd != ple_pkg::CMD_WRITE);
          if (sts.cmd != ple_pkg::CMD_READ) ctl.st_wr = ple_pkg::SW_VAL_SLOT;
          state_next = ple_pkg::S_RESP;
        end
      end
      ple_pkg::S_INS_ST: begin
        ctl.st_wr  = ple_pkg::SW_VAL_CNT;
        ctl.idx_op = ple_pkg::IX_CNT;
        state_next = ple_pkg::S_INS_RD;
      end
      ple_pkg::S_INS_RD: begin
        ctl.ord_ra = ple_pkg::ORA_IDX_M1;
        if (sts.idx_gt_pos) begin
          state_next = ple_pkg::S_INS_WR;
        end else begin
          ctl.ord_wr = ple_pkg::OW_PUT_POS;
          ctl.cnt_op = ple_pkg::CN_INC;
          state_next = ple_pkg::S_RESP;
        end
      end
      ple_pkg::S_INS_WR: begin
        ctl.ord_wr = ple_pkg::OW_SHIFT_UP;
        ctl.idx_op = ple_pkg::IX_DEC;
        state_next = ple_pkg::S_INS_RD;
      end
      ple_pkg::S_SC_RD: begin
        ctl.st_ra = ple_pkg::STA_IDX1;
        if (sts.idx1_lt_cnt) begin
          state_next = ple_pkg::S_SC_WR;
        end else begin
          ctl.idx_op = ple_pkg::IX_ZERO;
          state_next = ple_pkg::S_OC_RD;
        end
      end
      ple_pkg::S_SC_WR: begin
        ctl.st_wr  = ple_pkg::SW_RDATA_IDX;
        ctl.idx_op = ple_pkg::IX_INC;
        state_next = ple_pkg::S_SC_RD;
      end
      ple_pkg::S_OC_RD: begin
        ctl.ord_ra = ple_pkg::ORA_SRC;
        if (sts.idx1_lt_cnt) begin
          state_next = ple_pkg::S_OC_WR;
        end else begin
          ctl.cnt_op = ple_pkg::CN_DEC;
          state_next = ple_pkg::S_RESP;
        end
      end
      ple_pkg::S_OC_WR: begin
        ctl.ord_wr = ple_pkg::OW_COMPACT;
        ctl.idx_op = ple_pkg::IX_INC;
        state_next = ple_pkg::S_OC_RD;
      end
      ple_pkg::S_RESP: begin
        if (!sts.out_busy) begin
          ctl.out_load = 1'b1;
          state_next   = ple_pkg::S_IDLE;
        end
      end
      default: state_next = ple_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/ple_datapath.sv
`default_nettype none
module ple_datapath (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ple_pkg::req_t req,
  input  wire ple_pkg::ctl_t ctl,
  output ple_pkg::sts_t      sts,
  output ple_pkg::rsp_t      rsp,
  output logic               rsp_valid,
  input  wire logic          rsp_stall
);

  localparam int AW = ple_pkg::AW;
  localparam int CW = ple_pkg::CW;
  localparam int DW = ple_pkg::DATA_WIDTH;

  logic [DW-1:0] store_mem [ple_pkg::DEPTH];
  logic [AW-1:0] order_mem [ple_pkg::DEPTH];

  logic [2:0]    cmd;
  logic [8:0]    pos;
  logic [DW-1:0] val;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [AW-1:0] slot;
  logic [AW-1:0] ord_rdata;
  logic [DW-1:0] st_rdata;
  logic [DW-1:0] res_rv;
  logic [1:0]    res_stat;

  logic [CW:0]   idx1;
  logic [AW-1:0] ord_raddr, st_raddr, adj;

  assign idx1 = {1'b0, idx} + 1'b1;
  assign adj  = (ord_rdata > slot) ? ord_rdata - 1'b1 : ord_rdata;

  always_comb begin
    case (ctl.ord_ra)
      ple_pkg::ORA_POS:    ord_raddr = pos[AW-1:0];
      ple_pkg::ORA_IDX_M1: ord_raddr = AW'(idx - 1'b1);
      ple_pkg::ORA_SRC:    ord_raddr = ({1'b0, idx} < {1'b0, pos}) ? idx[AW-1:0]
                                                                   : idx1[AW-1:0];
      default:             ord_raddr = pos[AW-1:0];
    endcase
    st_raddr = (ctl.st_ra == ple_pkg::STA_IDX1) ? idx1[AW-1:0] : ord_rdata;
  end

  always_ff @(posedge clk) begin
    ord_rdata <= order_mem[ord_raddr];
    st_rdata  <= store_mem[st_raddr];
    case (ctl.st_wr)
      ple_pkg::SW_VAL_SLOT:  store_mem[slot]          <= val;
      ple_pkg::SW_VAL_CNT:   store_mem[count[AW-1:0]] <= val;
      ple_pkg::SW_RDATA_IDX: store_mem[idx[AW-1:0]]   <= st_rdata;
      default: ;
    endcase
    case (ctl.ord_wr)
      ple_pkg::OW_SHIFT_UP: order_mem[idx[AW-1:0]] <= ord_rdata;
      ple_pkg::OW_PUT_POS:  order_mem[pos[AW-1:0]] <= count[AW-1:0];
      ple_pkg::OW_COMPACT:  order_mem[idx[AW-1:0]] <= adj;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd      <= req.cmd;
      pos      <= req.position;
      val      <= req.value;
      res_rv   <= '0;
      res_stat <= ple_pkg::ST_OK;
    end
    if (ctl.slot_cap) slot <= ord_rdata;
    if (ctl.rv_cap) res_rv <= st_rdata;
    if (ctl.stat_set) res_stat <= ctl.stat;
    case (ctl.idx_op)
      ple_pkg::IX_CNT:  idx <= count;
      ple_pkg::IX_SLOT: idx <= CW'(slot);
      ple_pkg::IX_ZERO: idx <= '0;
      ple_pkg::IX_INC:  idx <= idx1[CW-1:0];
      ple_pkg::IX_DEC:  idx <= idx - 1'b1;
      default: ;
    endcase
    if (ctl.out_load) begin
      rsp.status      <= res_stat;
      rsp.read_value  <= 32'(res_rv);
      rsp.list_length <= 9'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      case (ctl.cnt_op)
        ple_pkg::CN_INC: count <= count + 1'b1;
        ple_pkg::CN_DEC: count <= count - 1'b1;
        ple_pkg::CN_CLR: count <= '0;
        default: ;
      endcase
      if (ctl.out_load)      rsp_valid <= 1'b1;
      else if (!rsp_stall)   rsp_valid <= 1'b0;
    end
  end

  assign sts.cmd         = cmd;
  assign sts.pos_lt_cnt  = ({1'b0, pos} < {1'b0, count});
  assign sts.pos_le_cnt  = ({1'b0, pos} <= {1'b0, count});
  assign sts.full        = (count >= CW'(ple_pkg::DEPTH));
  assign sts.idx_gt_pos  = ({1'b0, idx} > {1'b0, pos});
  assign sts.idx1_lt_cnt = (idx1 < {1'b0, count});
  assign sts.out_busy    = rsp_valid && rsp_stall;

endmodule
`default_nettype wire

### rtl/core/positional_list_engine.sv
// Each command is checked first, then runs its own path: read/write/swap go through the
// order table to the value store, insert shifts order entries up from the tail, and remove
// compacts both tables; a result waits while rsp_stall holds it. One command at a time;
// the read-then-write walks over the order table and value store must finish first.
// Reset (rst, synchronous, active high) empties the list and drops any pending result.
`default_nettype none
module positional_list_engine (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire ple_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output ple_pkg::rsp_t      rsp
);

  ple_pkg::ctl_t ctl;
  ple_pkg::sts_t sts;
  logic          busy;

  assign req_stall = busy;

  ple_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (req_valid && !busy),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy)
  );

  ple_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctl       (ctl),
    .sts       (sts),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

endmodule
`default_nettype wire

### rtl/core/ple_checker.sv
`default_nettype none
module ple_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_stall,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire ple_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result beat changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while busy");

  a_length: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.list_length <= 9'(ple_pkg::DEPTH) && rsp.status != 2'd3)
    else $error("bad result fields");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ple_pkg::ST_OK |-> rsp.read_value == '0)
    else $error("error beat carries data");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);
`default_nettype wire
